FILE: rtl/adc_moving_average_rms_unit_defines.svh
// Assertion macros shared by the RTL of the moving-average and RMS unit.
// Expects a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ADC_MOVING_AVERAGE_RMS_UNIT_DEFINES_SVH
`define ADC_MOVING_AVERAGE_RMS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AMR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/amr_pkg.sv
// Shared widths, constants and width helpers for the moving-average and RMS unit.
// No dependencies; every RTL module of the unit imports this package.
package amr_pkg;

    localparam int FV_W         = 9;     // filtered voltage, 0..300
    localparam int RMS_W        = 9;     // RMS voltage, 0..300
    localparam int SQ_W         = 17;    // square of a filtered voltage
    localparam int FULL_SCALE   = 300;   // hundredths of a volt at full scale
    localparam int MAX_SQ       = FULL_SCALE * FULL_SCALE;
    localparam int OUT_W        = ((FV_W + RMS_W + 7) / 8) * 8;

    localparam int DEF_TAPS     = 5;
    localparam int DEF_WINDOW   = 10;
    localparam int DEF_ADC_BITS = 8;

    localparam int FV_CNT_W     = $clog2(FV_W);
    localparam int RT_CNT_W     = $clog2(RMS_W);

    // Width of the running sum of squares over a window.
    function automatic int win_sum_width(input int window);
        return $clog2(window * MAX_SQ + 1);
    endfunction

    // Width of the saturating sample count.
    function automatic int count_width(input int window);
        return $clog2(window + 1);
    endfunction

endpackage

FILE: rtl/amr_filter.sv
// Sample delay line with running tap sum, bit-serial scaling divider and squarer.
// Depends on amr_pkg.
module amr_filter import amr_pkg::*; #(
    parameter int TAPS     = DEF_TAPS,
    parameter int ADC_BITS = DEF_ADC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [ADC_BITS-1:0] i_sample,
    output logic                o_done,
    output logic [FV_W-1:0]     o_filtered,
    output logic [SQ_W-1:0]     o_square
);

    localparam int ADC_MAX = (1 << ADC_BITS) - 1;
    localparam int DIVISOR = TAPS * ADC_MAX;
    localparam int TS_W    = $clog2(DIVISOR + 1);
    localparam int N_W     = $clog2(DIVISOR * FULL_SCALE + 1);
    localparam logic [N_W-1:0] DIV_TOP = N_W'(DIVISOR) << (FV_W - 1);

    logic [ADC_BITS-1:0] r_line [TAPS];
    logic [TS_W-1:0]     r_tap_sum;
    logic [TS_W-1:0]     n_tap_sum;
    logic [N_W-1:0]      r_rem;
    logic [N_W-1:0]      r_dsh;
    logic [FV_W-1:0]     r_q;
    logic [FV_CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]     r_square;
    logic                r_load;
    logic                r_run;
    logic                r_sq_go;
    logic                r_done;
    logic                w_ge;

    // The sum follows the line: add the new sample, drop the one leaving.
    assign n_tap_sum = r_tap_sum + TS_W'(i_sample) - TS_W'(r_line[0]);
    assign w_ge      = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= '{default: '0};
            r_tap_sum <= '0;
            r_load    <= 1'b0;
            r_run     <= 1'b0;
            r_sq_go   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_load  <= i_accept;
            r_sq_go <= r_run && (r_cnt == '0);
            r_done  <= r_sq_go;
            if (i_accept) begin
                for (int i = 0; i < TAPS - 1; i++) begin
                    r_line[i] <= r_line[i + 1];
                end
                r_line[TAPS-1] <= i_sample;
                r_tap_sum      <= n_tap_sum;
            end
            if (r_load) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
    end

    // Restoring division by a constant: the shifted divisor walks right one
    // place per cycle and one quotient bit is decided per cycle.
    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_rem <= N_W'(r_tap_sum) * N_W'(FULL_SCALE);
            r_dsh <= DIV_TOP;
            r_q   <= '0;
            r_cnt <= FV_CNT_W'(FV_W - 1);
        end else if (r_run) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[FV_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
        if (r_sq_go) begin
            r_square <= SQ_W'(r_q) * SQ_W'(r_q);
        end
    end

    assign o_done     = r_done;
    assign o_filtered = r_q;
    assign o_square   = r_square;

endmodule

FILE: rtl/amr_window.sv
// Window of squared voltages with running sum and saturating sample count.
// Depends on amr_pkg.
module amr_window import amr_pkg::*; #(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [SQ_W-1:0]                   i_square,
    output logic [win_sum_width(WINDOW)-1:0]  o_sum,
    output logic [count_width(WINDOW)-1:0]    o_count
);

    localparam int WS_W  = win_sum_width(WINDOW);
    localparam int CNT_W = count_width(WINDOW);

    logic [SQ_W-1:0]  r_win [WINDOW];
    logic [WS_W-1:0]  r_sum;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '{default: '0};
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_push) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[WINDOW-1] <= i_square;
            r_sum <= r_sum + WS_W'(i_square) - WS_W'(r_win[0]);
            if (r_count != CNT_W'(WINDOW)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

FILE: rtl/amr_divider.sv
// Serial divider for the mean of squares, two quotient bits per cycle.
// Depends on amr_pkg.
module amr_divider import amr_pkg::*; #(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [win_sum_width(WINDOW)-1:0]  i_dividend,
    input  logic [count_width(WINDOW)-1:0]    i_divisor,
    output logic                              o_done,
    output logic [SQ_W-1:0]                   o_quotient
);

    localparam int WS_W       = win_sum_width(WINDOW);
    localparam int CNT_W      = count_width(WINDOW);
    localparam int DIV_STEPS  = (WS_W + 1) / 2;
    localparam int DIV_W      = 2 * DIV_STEPS;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    logic [DIV_W-1:0]      r_num;
    logic [DIV_W-1:0]      n_num;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      n_rem;
    logic [CNT_W-1:0]      r_den;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_run;
    logic                  r_done;

    // The dividend leaves at the top of r_num while quotient bits enter at
    // the bottom; the remainder always stays below the divisor.
    always_comb begin
        logic [CNT_W:0] v_trial;
        logic           v_take;
        n_rem = r_rem;
        n_num = r_num;
        for (int k = 0; k < 2; k++) begin
            v_trial = {n_rem, n_num[DIV_W-1]};
            v_take  = v_trial >= {1'b0, r_den};
            n_rem   = v_take ? CNT_W'(v_trial - {1'b0, r_den}) : CNT_W'(v_trial);
            n_num   = {n_num[DIV_W-2:0], v_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DIV_W'(i_dividend);
            r_rem <= '0;
            r_den <= i_divisor;
            r_cnt <= STEP_CNT_W'(DIV_STEPS - 1);
        end else if (r_run) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num[SQ_W-1:0];

endmodule

FILE: rtl/amr_sqrt.sv
// Digit-by-digit floor square root, one radicand bit pair per cycle.
// Depends on amr_pkg.
module amr_sqrt import amr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_radicand,
    output logic             o_done,
    output logic [RMS_W-1:0] o_root
);

    localparam int RAD_W = 2 * RMS_W;
    localparam int REM_W = RMS_W + 2;

    logic [RAD_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W-1:0]    n_rem;
    logic [RMS_W-1:0]    r_root;
    logic [RMS_W-1:0]    n_root;
    logic [RT_CNT_W-1:0] r_cnt;
    logic                r_run;
    logic                r_done;
    logic [REM_W-1:0]    w_part;
    logic [REM_W-1:0]    w_trial;
    logic                w_take;

    // The partial remainder never exceeds twice the partial root, so its top
    // two bits are free before the next bit pair is shifted in.
    assign w_part  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_take  = w_part >= w_trial;
    assign n_rem   = w_take ? w_part - w_trial : w_part;
    assign n_root  = {r_root[RMS_W-2:0], w_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == '0)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_W'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= RT_CNT_W'(RMS_W - 1);
        end else if (r_run) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/adc_moving_average_rms_unit.sv
// Moving-average filter with running RMS. Every ADC sample gives one result:
// the average of the last TAPS samples in hundredths of a volt (0..300 over a
// 3.00 V full scale, truncated) and the floor square root of the mean of the
// last up to WINDOW squared averages. The unit works on one sample at a time
// and does so through three serial units in turn: the scaling divider, the
// mean divider (two bits per cycle over the width of the window's sum of
// squares) and the square root, with registered hand-overs between them. A
// finished result waits in the output register, or in the root unit while that
// register is still full, and the next sample can be taken in the cycle after the
// result is loaded. Depends on amr_pkg and the macro header.
`include "adc_moving_average_rms_unit_defines.svh"

module adc_moving_average_rms_unit import amr_pkg::*; #(
    parameter int TAPS     = DEF_TAPS,
    parameter int WINDOW   = DEF_WINDOW,
    parameter int ADC_BITS = DEF_ADC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((ADC_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,   // sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [OUT_W-1:0]                     m_axis_tdata    // filtered_voltage, rms_voltage
);

    localparam int WS_W  = win_sum_width(WINDOW);
    localparam int CNT_W = count_width(WINDOW);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILT = 5'b00010,
        ST_MEAN = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_HOLD = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_div_go;
    logic             r_out_valid;
    logic [FV_W-1:0]  r_out_filt;
    logic [RMS_W-1:0] r_out_rms;

    logic             w_accept;
    logic             w_slot_free;
    logic             w_load_out;
    logic             w_filt_done;
    logic             w_div_done;
    logic             w_root_done;
    logic [FV_W-1:0]  w_filtered;
    logic [SQ_W-1:0]  w_square;
    logic [WS_W-1:0]  w_win_sum;
    logic [CNT_W-1:0] w_count;
    logic [SQ_W-1:0]  w_mean;
    logic [RMS_W-1:0] w_root;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_load_out    = ((r_state == ST_ROOT && w_root_done) || r_state == ST_HOLD)
                           && w_slot_free;

    amr_filter #(
        .TAPS     (TAPS),
        .ADC_BITS (ADC_BITS)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_sample   (s_axis_tdata[ADC_BITS-1:0]),
        .o_done     (w_filt_done),
        .o_filtered (w_filtered),
        .o_square   (w_square)
    );

    amr_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_filt_done),
        .i_square (w_square),
        .o_sum    (w_win_sum),
        .o_count  (w_count)
    );

    amr_divider #(
        .WINDOW (WINDOW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (w_win_sum),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quotient (w_mean)
    );

    amr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_done),
        .i_radicand (w_mean),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                if (w_filt_done) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (w_div_done) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_root_done) begin
                    n_state = w_slot_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // The window sum is registered on the push, so the divider starts the cycle after.
            r_div_go <= w_filt_done;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_filt <= w_filtered;
            r_out_rms  <= w_root;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_rms, r_out_filt});

    `AMR_ASSERT_IMPL(a_filt_done_in_filt, w_filt_done, r_state == ST_FILT, "scaling done outside its phase")
    `AMR_ASSERT_IMPL(a_div_done_in_mean, w_div_done, r_state == ST_MEAN, "mean done outside its phase")
    `AMR_ASSERT_IMPL(a_root_done_in_root, w_root_done, r_state == ST_ROOT, "root done outside its phase")
    `AMR_ASSERT_NEXT(a_hold_release, r_state == ST_HOLD && w_slot_free, r_out_valid && r_state == ST_IDLE, "held result not delivered")

endmodule
